// ===== hdl/sfts_pkg.sv =====
// ----------------------------------------------------------------------------
// sfts_pkg
// Shared types and constants of the SPI NOR flash transaction sequencer.
// ----------------------------------------------------------------------------
package sfts_pkg;

   // Sizes
   localparam int PAGE_BYTES        = 256;
   localparam int MAX_REQUEST_BYTES = 4096;
   localparam int PAGE_W            = $clog2(PAGE_BYTES);
   localparam int LEN_W             = 13;
   localparam int ADDR_W            = 24;
   localparam int OFFS_W            = 12;
   localparam int SLEN_W            = 9;

   // Host request codes
   localparam logic [2:0] CMD_READ     = 3'd0;
   localparam logic [2:0] CMD_ERASE    = 3'd1;
   localparam logic [2:0] CMD_ERASE_NB = 3'd2;
   localparam logic [2:0] CMD_WRITE    = 3'd3;
   localparam logic [2:0] CMD_UNPROT   = 3'd4;
   localparam logic [2:0] CMD_READ_ID  = 3'd5;

   // SPI NOR opcodes
   localparam logic [7:0] OP_READ    = 8'h03;
   localparam logic [7:0] OP_ERASE4K = 8'h20;
   localparam logic [7:0] OP_PROGRAM = 8'h02;
   localparam logic [7:0] OP_WRSR    = 8'h01;
   localparam logic [7:0] OP_JEDEC   = 8'h9F;

   // Bytes returned by the JEDEC ID read
   localparam logic [LEN_W-1:0] JEDEC_ID_BYTES = LEN_W'(3);

   typedef struct packed {
      logic [2:0]        cmd;
      logic [ADDR_W-1:0] flash_address;
      logic [LEN_W-1:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic              poll_before;
      logic              enable_before;
      logic [7:0]        opcode;
      logic [ADDR_W-1:0] frame_address;
      logic              has_address;
      logic              send_zero_status;
      logic [SLEN_W-1:0] send_length;
      logic [LEN_W-1:0]  receive_length;
      logic [OFFS_W-1:0] buffer_offset;
      logic              poll_after;
      logic              last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_empty;
      logic desc_last;
   } ctl_sts_type;

endpackage

// ===== hdl/sfts_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfts_ctrl
// Sequencer state machine: takes a request, then issues one descriptor per
// free output slot until the datapath flags the last one.
// ----------------------------------------------------------------------------
module sfts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sfts_pkg::ctl_cmd_type ctl_cmd,
   input  sfts_pkg::ctl_sts_type ctl_sts
);
   import sfts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output slot is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      ctl_cmd.load    = 1'b0;
      ctl_cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ctl_cmd.load = req_valid;
            if (req_valid && !ctl_sts.req_empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl_cmd.advance = out_free;
            if (out_free && ctl_sts.desc_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result beat until taken
   always_comb begin
      if (ctl_cmd.advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/sfts_dpath.sv =====
// ----------------------------------------------------------------------------
// sfts_dpath
// Request registers, page chunking and the descriptor output register.
// ----------------------------------------------------------------------------
module sfts_dpath (
   input  logic                  clock,
   input  sfts_pkg::req_type     req_payload,
   output sfts_pkg::rsp_type     rsp_payload,
   input  sfts_pkg::ctl_cmd_type ctl_cmd,
   output sfts_pkg::ctl_sts_type ctl_sts
);
   import sfts_pkg::*;

   logic [2:0]        cmd_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [OFFS_W-1:0] offs_ff, offs_in;
   rsp_type           rsp_ff;
   rsp_type           desc;
   logic [LEN_W-1:0]  req_len;
   logic [PAGE_W:0]   page_rem;
   logic [LEN_W-1:0]  chunk;
   logic              req_empty;

   // Saturate the requested length
   always_comb begin
      if (req_payload.byte_count > LEN_W'(MAX_REQUEST_BYTES)) begin
         req_len = LEN_W'(MAX_REQUEST_BYTES);
      end else begin
         req_len = req_payload.byte_count;
      end
   end

   // Flag requests that expand to nothing
   always_comb begin
      case (req_payload.cmd)
         CMD_READ, CMD_WRITE:                  req_empty = (req_len == '0);
         CMD_ERASE, CMD_ERASE_NB, CMD_UNPROT,
         CMD_READ_ID:                          req_empty = 1'b0;
         default:                              req_empty = 1'b1;
      endcase
   end

   // Bytes up to the next page boundary, capped by what remains
   assign page_rem = (PAGE_W+1)'(PAGE_BYTES) - {1'b0, addr_ff[PAGE_W-1:0]};
   always_comb begin
      if (LEN_W'(page_rem) < len_ff) begin
         chunk = LEN_W'(page_rem);
      end else begin
         chunk = len_ff;
      end
   end

   // Build the current descriptor
   always_comb begin
      desc = '0;
      case (cmd_ff)
         CMD_READ: begin
            desc.poll_before    = 1'b1;
            desc.opcode         = OP_READ;
            desc.frame_address  = addr_ff;
            desc.has_address    = 1'b1;
            desc.receive_length = len_ff;
            desc.last           = 1'b1;
         end
         CMD_ERASE, CMD_ERASE_NB: begin
            desc.poll_before   = 1'b1;
            desc.enable_before = 1'b1;
            desc.opcode        = OP_ERASE4K;
            desc.frame_address = addr_ff;
            desc.has_address   = 1'b1;
            desc.poll_after    = (cmd_ff == CMD_ERASE);
            desc.last          = 1'b1;
         end
         CMD_WRITE: begin
            desc.poll_before   = 1'b1;
            desc.enable_before = 1'b1;
            desc.opcode        = OP_PROGRAM;
            desc.frame_address = addr_ff;
            desc.has_address   = 1'b1;
            desc.send_length   = SLEN_W'(chunk);
            desc.buffer_offset = offs_ff;
            desc.poll_after    = 1'b1;
            desc.last          = (len_ff == chunk);
         end
         CMD_UNPROT: begin
            desc.enable_before    = 1'b1;
            desc.opcode           = OP_WRSR;
            desc.send_zero_status = 1'b1;
            desc.poll_after       = 1'b1;
            desc.last             = 1'b1;
         end
         CMD_READ_ID: begin
            desc.opcode         = OP_JEDEC;
            desc.receive_length = JEDEC_ID_BYTES;
            desc.last           = 1'b1;
         end
         default: begin
            desc.last = 1'b1;
         end
      endcase
   end

   assign ctl_sts = '{req_empty: req_empty, desc_last: desc.last};

   // Load a new request or step past the chunk just issued
   always_comb begin
      addr_in = addr_ff;
      len_in  = len_ff;
      offs_in = offs_ff;
      if (ctl_cmd.load) begin
         addr_in = req_payload.flash_address;
         len_in  = req_len;
         offs_in = '0;
      end else if (ctl_cmd.advance) begin
         addr_in = addr_ff + ADDR_W'(chunk);
         len_in  = len_ff - chunk;
         offs_in = offs_ff + OFFS_W'(chunk);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         cmd_ff <= req_payload.cmd;
      end
      addr_ff <= addr_in;
      len_ff  <= len_in;
      offs_ff <= offs_in;
      if (ctl_cmd.advance) begin
         rsp_ff <= desc;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/spi_flash_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// spi_flash_transaction_sequencer
// Expands host flash requests into SPI NOR transaction descriptors.
// ----------------------------------------------------------------------------
//   channel   direction  beat
//   req_      in         one host request (cmd, address, byte count)
//   rsp_      out        one transaction descriptor
//
// A request is taken, then a descriptor is issued whenever the output register
// is free, so a write of 4096 bytes that does not start on a page boundary
// expands to 17 descriptors, 16 when it does.
// req_stall stays high until the last descriptor is in the output register.
// A stall on rsp_ holds the output register and pauses the sequencer.
// Reset clears the state machine and the output valid only.
// ----------------------------------------------------------------------------
module spi_flash_transaction_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sfts_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sfts_pkg::rsp_type rsp_payload
);
   import sfts_pkg::*;

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   sfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_cmd   (ctl_cmd),
      .ctl_sts   (ctl_sts)
   );

   sfts_dpath u_dpath (
      .clock       (clock),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .ctl_cmd     (ctl_cmd),
      .ctl_sts     (ctl_sts)
   );

endmodule
